// File: sv/shs_pkg.sv
// Package for the SHA-256 stream hasher.
// Holds the sequencer state type, round constants, initial hash values and
// the SHA-256 bit functions; it depends on nothing else.
`default_nettype none

package shs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// File: sv/sha256_stream_hasher_core.sv
// SHA-256 stream hasher top level: byte absorb, padding, compression and digest output.
// Depends on shs_pkg for the state type, constants and bit functions.
//
// Usage: each input beat carries one item. s_tuser = 0 absorbs the byte in
// s_tdata; s_tuser = 1 finishes the message, pads it and returns the digest.
// An absorb beat is taken while s_tready is high; the one that fills a 64-byte
// block then keeps s_tready low while the working variables are loaded, all
// 64 rounds run on the single shared round unit and the result is folded into
// the chaining state. A finish beat pads the message and compresses one block,
// or two when more than 55 bytes are pending and a second block is needed, and
// then the eight digest words leave as eight beats on the master side,
// index 0 first, with m_tlast on the eighth. Input is not accepted while the
// digest is being sent; a receiver stall simply holds the current word. After
// the eighth word is taken the context returns to the initial hash values.
// Reset is synchronous and puts the block in that same initial context with
// an empty buffer; the block buffer itself is not cleared, since every byte
// is written before it is used.
`default_nettype none

module sha256_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // digest_word, word_index, zero fill
  output logic             m_tlast    // final_word
);

  shs_pkg::state_t state, state_next;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] chain [8];
  logic [5:0]  rnd;
  logic [5:0]  fill;
  logic [63:0] bitlen;
  logic        finishing;
  logic        len_pending;
  logic [2:0]  emit_idx;

  logic        in_beat;
  logic        out_beat;
  logic [31:0] t1, t2, wnew;
  logic [4:0]  lane_shift;

  assign in_beat    = s_tvalid && s_tready;
  assign out_beat   = m_tvalid && m_tready;
  assign lane_shift = {~fill[1:0], 3'b000};

  assign t1 = v[7] + shs_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shs_pkg::ROUND_K[rnd] + w[0];
  assign t2 = shs_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign wnew = shs_pkg::ssig1(w[14]) + w[9] + shs_pkg::ssig0(w[1]) + w[0];

  always_comb begin
    state_next = state;
    unique case (state)
      shs_pkg::ST_IDLE: begin
        if (s_tvalid && (s_tuser || fill == 6'd63)) begin
          state_next = shs_pkg::ST_LOAD;
        end
      end
      shs_pkg::ST_LOAD:  state_next = shs_pkg::ST_ROUND;
      shs_pkg::ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = shs_pkg::ST_FOLD;
        end
      end
      shs_pkg::ST_FOLD: begin
        priority if (len_pending) begin
          state_next = shs_pkg::ST_LOAD;
        end else if (finishing) begin
          state_next = shs_pkg::ST_EMIT;
        end else begin
          state_next = shs_pkg::ST_IDLE;
        end
      end
      shs_pkg::ST_EMIT: begin
        if (m_tready && emit_idx == 3'd7) begin
          state_next = shs_pkg::ST_IDLE;
        end
      end
      default: state_next = shs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == shs_pkg::ST_IDLE);
    m_tvalid = (state == shs_pkg::ST_EMIT);
    m_tdata  = {5'b0, emit_idx, chain[emit_idx]};
    m_tlast  = (emit_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= shs_pkg::INIT_HASH[i];
      end
      fill        <= '0;
      bitlen      <= '0;
      finishing   <= 1'b0;
      len_pending <= 1'b0;
      emit_idx    <= '0;
      rnd         <= '0;
    end else begin
      unique case (state)
        shs_pkg::ST_IDLE: begin
          if (in_beat && !s_tuser) begin
            w[fill[5:2]][lane_shift +: 8] <= s_tdata;
            fill   <= fill + 6'd1;
            bitlen <= bitlen + 64'd8;
          end else if (in_beat) begin
            for (int j = 0; j < 16; j++) begin
              if (j < 14 || fill >= shs_pkg::LEN_SLOT) begin
                for (int l = 0; l < 4; l++) begin
                  if (6'(4 * j + l) == fill) begin
                    w[j][8 * (3 - l) +: 8] <= shs_pkg::PAD_BYTE;
                  end else if (6'(4 * j + l) > fill) begin
                    w[j][8 * (3 - l) +: 8] <= 8'h00;
                  end
                end
              end
            end
            if (fill < shs_pkg::LEN_SLOT) begin
              w[14] <= bitlen[63:32];
              w[15] <= bitlen[31:0];
            end
            len_pending <= (fill >= shs_pkg::LEN_SLOT);
            finishing   <= 1'b1;
          end
        end
        shs_pkg::ST_LOAD: begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= chain[i];
          end
          rnd <= '0;
        end
        shs_pkg::ST_ROUND: begin
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i + 1];
          end
          w[15] <= wnew;
          rnd   <= rnd + 6'd1;
        end
        shs_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          fill <= '0;
          if (len_pending) begin
            for (int i = 0; i < 14; i++) begin
              w[i] <= '0;
            end
            w[14]       <= bitlen[63:32];
            w[15]       <= bitlen[31:0];
            len_pending <= 1'b0;
          end
        end
        shs_pkg::ST_EMIT: begin
          if (out_beat) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= shs_pkg::INIT_HASH[i];
              end
              fill      <= '0;
              bitlen    <= '0;
              finishing <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_one_side_open: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("Input and output sides are open at the same time.");

  a_load_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    state == shs_pkg::ST_LOAD |=> state == shs_pkg::ST_ROUND && rnd == 6'd0)
    else $error("Round sequence did not start from round zero.");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    state == shs_pkg::ST_ROUND && rnd == 6'd63 |=> state == shs_pkg::ST_FOLD)
    else $error("Compression did not end after the last round.");

  a_context_cleared: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_tlast |=> fill == 6'd0 && bitlen == 64'd0 && !finishing)
    else $error("Context was not cleared after the last digest beat.");

endmodule

`default_nettype wire

// File: dv/sha256_stream_hasher_core_test.sv
// Self-checking testbench for sha256_stream_hasher_core: byte and finish beats in, digest words out.
// Predicts every digest with its own SHA-256 model and checks each output beat in order.
// Depends only on the RTL top level.
module sha256_stream_hasher_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int ITEM_TARGET = 470;

  localparam logic [31:0] RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic       op;
    logic [7:0] data;
    bit         drain_after;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY3} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  byte_item_t   msg_items[$];
  digest_beat_t expected_digest[$];

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [6:0]  fill_cnt;
  logic [63:0] bit_len;

  int error_count = 0;
  int beats_in = 0;
  int words_seen = 0;
  int messages_done = 0;
  int extra_pad_blocks = 0;
  int burst_left = 1;
  int gap_left = 0;
  bit drain_wait = 0;
  int rx_cycle = 0;
  int holdoff_left = 0;
  bit holdoff_done = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int idle_cycles = 0;

  sha256_stream_hasher_core uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic reset_context();
    for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    fill_cnt = 7'd0;
    bit_len = 64'd0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2, x, y;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      x = w[t-15];
      y = w[t-2];
      w[t] = w[t-16] + (rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3)) + w[t-7]
             + (rot_right(y, 17) ^ rot_right(y, 19) ^ (y >> 10));
    end
    va = hash_state[0]; vb = hash_state[1]; vc = hash_state[2]; vd = hash_state[3];
    ve = hash_state[4]; vf = hash_state[5]; vg = hash_state[6]; vh = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = vh + (rot_right(ve, 6) ^ rot_right(ve, 11) ^ rot_right(ve, 25))
           + ((ve & vf) ^ (~ve & vg)) + RC[t] + w[t];
      t2 = (rot_right(va, 2) ^ rot_right(va, 13) ^ rot_right(va, 22))
           + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    hash_state[0] += va; hash_state[1] += vb; hash_state[2] += vc; hash_state[3] += vd;
    hash_state[4] += ve; hash_state[5] += vf; hash_state[6] += vg; hash_state[7] += vh;
  endtask

  task automatic hash_model_step(input logic op, input logic [7:0] data);
    digest_beat_t beat;
    if (op == OP_ABSORB) begin
      msg_block[fill_cnt[5:0]] = data;
      fill_cnt = fill_cnt + 7'd1;
      bit_len = bit_len + 64'd8;
      if (fill_cnt >= 7'd64) begin
        compress_block();
        fill_cnt = 7'd0;
      end
    end else begin
      fill_cnt = fill_cnt & 7'd63;
      msg_block[fill_cnt[5:0]] = PAD_MARK;
      fill_cnt = fill_cnt + 7'd1;
      if (fill_cnt > 7'd56) begin
        while (fill_cnt < 7'd64) begin
          msg_block[fill_cnt[5:0]] = 8'h00;
          fill_cnt = fill_cnt + 7'd1;
        end
        compress_block();
        fill_cnt = 7'd0;
        extra_pad_blocks++;
      end
      while (fill_cnt < 7'd56) begin
        msg_block[fill_cnt[5:0]] = 8'h00;
        fill_cnt = fill_cnt + 7'd1;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[8*(7-i) +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        beat.word = hash_state[i];
        beat.idx = 3'(i);
        beat.last = (i == 7);
        expected_digest = {expected_digest, beat};
      end
      messages_done++;
      reset_context();
    end
  endtask

  task automatic queue_beat(input logic op, input logic [7:0] data, input bit drain);
    byte_item_t it;
    it.op = op;
    it.data = data;
    it.drain_after = drain;
    msg_items = {msg_items, it};
  endtask

  // Sender: bursts and gaps, optional pause until all digests are back.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        hash_model_step(s_tuser, s_tdata);
        if (msg_items[0].drain_after) drain_wait = 1;
        void'(msg_items.pop_front());
        beats_in++;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (drain_wait && expected_digest.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        drain_wait = 0;
        if (msg_items.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tuser <= msg_items[0].op;
          s_tdata <= msg_items[0].data;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(100, 250);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (!holdoff_done && holdoff_left == 0 && words_seen >= 16 && m_tvalid && s_tvalid)
        holdoff_left = HOLDOFF_CYCLES;
      if (holdoff_left > 0) begin
        holdoff_left--;
        if (holdoff_left == 0) holdoff_done = 1;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          default:   m_tready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (expected_digest.size() == 0) begin
        $display("%0t: unexpected digest beat word=%h index=%0d last=%b",
                 $time, m_tdata[31:0], m_tdata[34:32], m_tlast);
        error_count++;
      end else begin
        want = expected_digest.pop_front();
        if (m_tdata[31:0] !== want.word || m_tdata[34:32] !== want.idx
            || m_tlast !== want.last) begin
          $display("%0t: digest mismatch expected word=%h index=%0d last=%b, got word=%h index=%0d last=%b",
                   $time, want.word, want.idx, want.last,
                   m_tdata[31:0], m_tdata[34:32], m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int pick;
    int msg_no;
    int boundary_len [8];
    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
    reset_context();

    // Empty message, "abc", extreme bytes, and back-to-back finishes.
    queue_beat(OP_FINISH, 8'hff, 1);
    queue_beat(OP_ABSORB, 8'h61, 0);
    queue_beat(OP_ABSORB, 8'h62, 0);
    queue_beat(OP_ABSORB, 8'h63, 0);
    queue_beat(OP_FINISH, 8'h00, 0);
    queue_beat(OP_ABSORB, 8'h00, 0);
    queue_beat(OP_ABSORB, 8'hff, 0);
    queue_beat(OP_ABSORB, 8'h80, 0);
    queue_beat(OP_ABSORB, 8'h7f, 0);
    queue_beat(OP_ABSORB, 8'h01, 0);
    queue_beat(OP_FINISH, 8'h5a, 0);
    queue_beat(OP_FINISH, 8'h00, 1);

    msg_no = 0;
    while (msg_items.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 24);
      else if (pick < 9) len = boundary_len[$urandom_range(0, 7)];
      else len = $urandom_range(0, 130);
      for (int i = 0; i < len; i++) queue_beat(OP_ABSORB, 8'($urandom_range(0, 255)), 0);
      msg_no++;
      queue_beat(OP_FINISH, 8'($urandom_range(0, 255)), (msg_no % 9 == 0));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (msg_items.size() != 0) @(posedge clk);
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats and %0d messages, %0d of them needing an extra pad block.",
             beats_in, messages_done, extra_pad_blocks);
    $display("%0d digest words were checked under random sender gaps and receiver stalls.",
             words_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
